@@ sv/csq_pkg.sv @@
package csq_pkg;

	localparam int DEPTH = 32;
	localparam int ID_W = 8;

	localparam logic [2:0] CMD_OPEN    = 3'd0;
	localparam logic [2:0] CMD_WAIT    = 3'd1;
	localparam logic [2:0] CMD_SIGNAL  = 3'd2;
	localparam logic [2:0] CMD_CLOSE   = 3'd3;
	localparam logic [2:0] CMD_ABANDON = 3'd4;

	localparam logic [2:0] K_PROCEED      = 3'd0;
	localparam logic [2:0] K_BLOCKED      = 3'd1;
	localparam logic [2:0] K_WOKEN_OK     = 3'd2;
	localparam logic [2:0] K_WOKEN_CLOSED = 3'd3;
	localparam logic [2:0] K_FREED_DEAD   = 3'd4;
	localparam logic [2:0] K_QUEUE_FULL   = 3'd5;
	localparam logic [2:0] K_ACK          = 3'd6;

	typedef struct packed {
		logic            valid;
		logic            dead;
		logic [ID_W-1:0] id;
	} entry_t;

	typedef struct packed {
		logic            clear;
		logic            pop;
		logic            enq;
		logic            abandon;
		logic [ID_W-1:0] tid;
	} ctl_t;

endpackage

@@ sv/csq_cell.sv @@
module csq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  csq_pkg::ctl_t   ctl,
	input  logic            prev_valid,
	input  csq_pkg::entry_t nxt,
	output csq_pkg::entry_t ent
);

	logic                     valid_q;
	logic                     dead_q;
	logic [csq_pkg::ID_W-1:0] id_q;
	logic                     load;

	assign load = ctl.enq && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dead_q  <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			dead_q  <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= nxt.valid;
			dead_q  <= nxt.dead;
		end else if (load) begin
			valid_q <= 1'b1;
			dead_q  <= 1'b0;
		end else if (ctl.abandon && valid_q && id_q == ctl.tid) begin
			dead_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			id_q <= nxt.id;
		end else if (load) begin
			id_q <= ctl.tid;
		end
	end

	assign ent.valid = valid_q;
	assign ent.dead  = dead_q;
	assign ent.id    = id_q;

endmodule

@@ sv/counting_semaphore_wait_queue_unit.sv @@
// Counting semaphore with a FIFO wait queue of thread ids.
// Command channel: start with command, thread_id, init_count; a beat is taken
// when start is high and busy is low. Commands: open, wait, signal, close,
// abandon; codes 5 to 7 are taken and dropped without a result.
// Result channel: strobe marks one beat of kind, thread_id_res, last for one
// cycle; the receiver cannot stall, so no backpressure exists.
// The queue is a row of 32 cells with the head in cell 0; a pop shifts every
// cell one place toward the head, a wait fills the first empty cell, and an
// abandon compares all cells at once.
// Open, wait and abandon give their single result in the cycle after the
// beat is taken, and busy stays low.
// Signal and close hold busy while they pop entries (one pop and one result
// per cycle), and end with an ack when the queue runs empty; the last result
// is on the ports in the first cycle with busy low.
// Reset clears the count, the cell valid and dead bits and the sequencer.
module counting_semaphore_wait_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [7:0]  thread_id,
	input  logic [31:0] init_count,
	output logic        strobe,
	output logic [2:0]  kind,
	output logic [7:0]  thread_id_res,
	output logic        last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SIG  = 2'd1;
	localparam logic [1:0] ST_CLS  = 2'd2;

	logic [1:0]      state_q, state_d;
	logic [31:0]     count_q, count_d;
	logic            strobe_q, strobe_d;
	logic [2:0]      kind_q, kind_d;
	logic [7:0]      tid_res_q, tid_res_d;
	logic            last_q, last_d;
	csq_pkg::ctl_t   ctl;
	csq_pkg::entry_t ent [csq_pkg::DEPTH];
	csq_pkg::entry_t hd;
	logic            accept;
	logic            full;

	assign accept = start && !busy;
	assign hd     = ent[0];
	assign full   = ent[csq_pkg::DEPTH-1].valid;

	genvar gi;
	generate
		for (gi = 0; gi < csq_pkg::DEPTH; gi++) begin : g_cell
			csq_pkg::entry_t nxt;
			logic            prev_valid;
			if (gi == csq_pkg::DEPTH - 1) begin : g_tail
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = ent[gi+1];
			end
			if (gi == 0) begin : g_head
				assign prev_valid = 1'b1;
			end else begin : g_body
				assign prev_valid = ent[gi-1].valid;
			end
			csq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_valid (prev_valid),
				.nxt        (nxt),
				.ent        (ent[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		strobe_d  = 1'b0;
		kind_d    = csq_pkg::K_ACK;
		tid_res_d = '0;
		last_d    = 1'b0;
		ctl       = '0;
		ctl.tid   = thread_id[csq_pkg::ID_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						csq_pkg::CMD_OPEN: begin
							ctl.clear = 1'b1;
							count_d   = init_count;
							strobe_d  = 1'b1;
							last_d    = 1'b1;
						end
						csq_pkg::CMD_WAIT: begin
							strobe_d  = 1'b1;
							last_d    = 1'b1;
							tid_res_d = 8'(ctl.tid);
							if (count_q != '0) begin
								count_d = count_q - 32'd1;
								kind_d  = csq_pkg::K_PROCEED;
							end else if (full) begin
								kind_d = csq_pkg::K_QUEUE_FULL;
							end else begin
								ctl.enq = 1'b1;
								kind_d  = csq_pkg::K_BLOCKED;
							end
						end
						csq_pkg::CMD_SIGNAL: state_d = ST_SIG;
						csq_pkg::CMD_CLOSE:  state_d = ST_CLS;
						csq_pkg::CMD_ABANDON: begin
							ctl.abandon = 1'b1;
							strobe_d    = 1'b1;
							last_d      = 1'b1;
							tid_res_d   = 8'(ctl.tid);
						end
						default: ;
					endcase
				end
			end
			ST_SIG: begin
				strobe_d = 1'b1;
				if (hd.valid) begin
					ctl.pop   = 1'b1;
					tid_res_d = 8'(hd.id);
					if (hd.dead) begin
						kind_d = csq_pkg::K_FREED_DEAD;
					end else begin
						kind_d  = csq_pkg::K_WOKEN_OK;
						last_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					if (count_q != '1) count_d = count_q + 32'd1;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CLS: begin
				strobe_d = 1'b1;
				if (hd.valid) begin
					ctl.pop   = 1'b1;
					tid_res_d = 8'(hd.id);
					kind_d    = hd.dead ? csq_pkg::K_FREED_DEAD : csq_pkg::K_WOKEN_CLOSED;
				end else begin
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		tid_res_q <= tid_res_d;
		last_q    <= last_d;
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign kind          = kind_q;
	assign thread_id_res = tid_res_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_blocked_queued: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && kind_q == csq_pkg::K_BLOCKED |-> hd.valid)
		else $error("blocked beat but queue empty");
	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && kind_q == csq_pkg::K_QUEUE_FULL |-> full)
		else $error("queue full beat with free cell");
	a_woken_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && kind_q == csq_pkg::K_WOKEN_OK |-> last_q)
		else $error("woken ok beat not last");
	a_close_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLS && state_d == ST_IDLE |=> !hd.valid)
		else $error("queue not empty after close");
`endif

endmodule
